>>> rtl/rect_intersect_outzones_assert.svh
// assertion macros used by the port-level checker
`ifndef RECT_INTERSECT_OUTZONES_ASSERT_SVH
`define RECT_INTERSECT_OUTZONES_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RIO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RIO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/rio_pkg.sv
// types and constants for the rectangle intersection and border strip block
package rio_pkg;

  localparam int NUM_SLOTS = 5;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam int SLOT_INTER  = 0;
  localparam int SLOT_TOP    = 1;
  localparam int SLOT_BOTTOM = 2;
  localparam int SLOT_LEFT   = 3;
  localparam int SLOT_RIGHT  = 4;

  typedef enum logic [2:0] {
    ZK_EMPTY  = 3'd0,
    ZK_INTER  = 3'd1,
    ZK_TOP    = 3'd2,
    ZK_BOTTOM = 3'd3,
    ZK_LEFT   = 3'd4,
    ZK_RIGHT  = 3'd5
  } zone_kind_t;

  typedef struct packed {
    logic signed [15:0] domain_x;
    logic signed [15:0] domain_y;
    logic [14:0]        domain_w;
    logic [14:0]        domain_h;
    logic signed [15:0] req_x;
    logic signed [15:0] req_y;
    logic [14:0]        req_w;
    logic [14:0]        req_h;
  } rect_item_t;

  typedef struct packed {
    zone_kind_t         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } zone_t;

endpackage

>>> rtl/rio_zones.sv
// computes the intersection and the four border strips of one item
module rio_zones
  import rio_pkg::*;
(
  input  rect_item_t           item,
  output zone_t                zones [NUM_SLOTS],
  output logic [NUM_SLOTS-1:0] present
);

  logic signed [17:0] dx, dy, rx, ry, dw, dh, rw, rh;
  logic signed [17:0] d_x1, d_y1, r_x1, r_y1;
  logic signed [17:0] nx, ny, iw, ih;
  logic signed [18:0] top, bottom, left, right, adj, strip_h, tp;
  logic signed [18:0] bottom_y, right_x;
  logic               overlap;

  always_comb begin
    dx = {{2{item.domain_x[15]}}, item.domain_x};
    dy = {{2{item.domain_y[15]}}, item.domain_y};
    rx = {{2{item.req_x[15]}}, item.req_x};
    ry = {{2{item.req_y[15]}}, item.req_y};
    dw = {3'b000, item.domain_w};
    dh = {3'b000, item.domain_h};
    rw = {3'b000, item.req_w};
    rh = {3'b000, item.req_h};

    d_x1 = dx + dw;
    d_y1 = dy + dh;
    r_x1 = rx + rw;
    r_y1 = ry + rh;
    nx   = (dx > rx) ? dx : rx;
    ny   = (dy > ry) ? dy : ry;
    iw   = ((d_x1 < r_x1) ? d_x1 : r_x1) - nx;
    ih   = ((d_y1 < r_y1) ? d_y1 : r_y1) - ny;
    overlap = (iw > 18'sd0) && (ih > 18'sd0);

    top    = {dy[17], dy} - {ry[17], ry};
    bottom = {rh[17], rh} - {dh[17], dh} - top;
    left   = {dx[17], dx} - {rx[17], rx};
    right  = {rw[17], rw} - {dw[17], dw} - left;
    adj    = ((top < 19'sd0) ? top : 19'sd0) + ((bottom < 19'sd0) ? bottom : 19'sd0);
    // side strips only cover the rows shared with the domain
    strip_h  = {dh[17], dh} + adj;
    tp       = (top > 19'sd0) ? top : 19'sd0;
    bottom_y = top + {dh[17], dh};
    right_x  = left + {dw[17], dw};

    if (overlap) begin
      zones[SLOT_INTER] = '{kind: ZK_INTER, x: nx[15:0], y: ny[15:0],
                            w: iw[14:0], h: ih[14:0]};
    end else begin
      zones[SLOT_INTER] = '{kind: ZK_EMPTY, x: 16'sd0, y: 16'sd0, w: 15'd0, h: 15'd0};
    end
    zones[SLOT_TOP]    = '{kind: ZK_TOP, x: 16'sd0, y: 16'sd0,
                           w: item.req_w, h: top[14:0]};
    zones[SLOT_BOTTOM] = '{kind: ZK_BOTTOM, x: 16'sd0, y: bottom_y[15:0],
                           w: item.req_w, h: bottom[14:0]};
    zones[SLOT_LEFT]   = '{kind: ZK_LEFT, x: 16'sd0, y: tp[15:0],
                           w: left[14:0], h: strip_h[14:0]};
    zones[SLOT_RIGHT]  = '{kind: ZK_RIGHT, x: right_x[15:0], y: tp[15:0],
                           w: right[14:0], h: strip_h[14:0]};

    present[SLOT_INTER]  = 1'b1;
    present[SLOT_TOP]    = overlap && (top > 19'sd0);
    present[SLOT_BOTTOM] = overlap && (bottom > 19'sd0);
    present[SLOT_LEFT]   = overlap && (left > 19'sd0);
    present[SLOT_RIGHT]  = overlap && (right > 19'sd0);
  end

endmodule

>>> rtl/rect_intersect_outzones.sv
// Rectangle intersection with border strips. Each accepted item (domain and
// request rectangle) yields one to five zones: the intersection in absolute
// coordinates, then the top, bottom, left and right strips of the request
// outside the domain, request-relative; no overlap gives one empty zone.
// Zones leave one per cycle through the output register while out_stall is
// low, zone_last on the final one. An item stays in the input register until
// its last zone moves into the single output register, which takes one zone
// at a time; the next item is accepted in the cycle that the previous item's
// last zone moves into the output register. Each zone passes through the
// input register and then the output register.
module rect_intersect_outzones
  import rio_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] domain_x,
  input  logic signed [15:0] domain_y,
  input  logic [14:0]        domain_w,
  input  logic [14:0]        domain_h,
  input  logic signed [15:0] req_x,
  input  logic signed [15:0] req_y,
  input  logic [14:0]        req_w,
  input  logic [14:0]        req_h,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         zone_kind,
  output logic signed [15:0] zone_x,
  output logic signed [15:0] zone_y,
  output logic [14:0]        zone_w,
  output logic [14:0]        zone_h,
  output logic               zone_last
);

  rect_item_t           item;
  logic                 item_valid;
  logic [NUM_SLOTS-1:0] sent;

  zone_t                zones [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] present;
  logic [NUM_SLOTS-1:0] remaining;
  logic [NUM_SLOTS-1:0] sel_bit;
  logic [SLOT_W-1:0]    sel_idx;
  logic                 sel_last;
  logic                 load;
  logic                 in_take;

  zone_t                out_zone;

  rio_zones u_zones (
    .item    (item),
    .zones   (zones),
    .present (present)
  );

  // lowest pending slot goes next
  always_comb begin
    remaining = present & ~sent;
    sel_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        sel_idx = SLOT_W'(i);
      end
    end
    sel_bit  = NUM_SLOTS'(1) << sel_idx;
    sel_last = (remaining & ~sel_bit) == '0;
  end

  assign load     = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !(load && sel_last);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      sent       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid <= 1'b1;
        sent       <= '0;
      end else if (load) begin
        if (sel_last) begin
          item_valid <= 1'b0;
        end
        sent <= sent | sel_bit;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{domain_x: domain_x, domain_y: domain_y, domain_w: domain_w,
                domain_h: domain_h, req_x: req_x, req_y: req_y,
                req_w: req_w, req_h: req_h};
    end
    if (load) begin
      out_zone  <= zones[sel_idx];
      zone_last <= sel_last;
    end
  end

  assign zone_kind = out_zone.kind;
  assign zone_x    = out_zone.x;
  assign zone_y    = out_zone.y;
  assign zone_w    = out_zone.w;
  assign zone_h    = out_zone.h;

endmodule

>>> rtl/rio_checker.sv
// port-level checks on the zone stream, bound to the top level
`include "rect_intersect_outzones_assert.svh"

module rio_checker
  import rio_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         zone_kind,
  input logic signed [15:0] zone_x,
  input logic signed [15:0] zone_y,
  input logic [14:0]        zone_w,
  input logic [14:0]        zone_h,
  input logic               zone_last
);

  // a stalled zone holds
  `RIO_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(zone_kind) && $stable(zone_x) && $stable(zone_y)
      && $stable(zone_w) && $stable(zone_h) && $stable(zone_last))

  // empty result is all zero and ends its item
  `RIO_ASSERT_SAME(a_empty_zero, out_valid && zone_kind == ZK_EMPTY,
    zone_last && zone_x == 16'sd0 && zone_y == 16'sd0 && zone_w == 15'd0 && zone_h == 15'd0)

  // every real zone has area
  `RIO_ASSERT_SAME(a_zone_area, out_valid && zone_kind != ZK_EMPTY,
    zone_w != 15'd0 && zone_h != 15'd0)

  // zones of one item follow back to back in rising kind order
  `RIO_ASSERT_NEXT(a_zone_order, out_valid && !out_stall && !zone_last,
    out_valid && zone_kind > $past(zone_kind) && zone_kind != ZK_EMPTY)

endmodule

bind rect_intersect_outzones rio_checker u_rio_checker (.*);
